// File: src/tvmv_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tvmv_pkg: shared types and constants
// Character codes, field phases, outcome codes and the word type of the
// tag=value message validator.
// ----------------------------------------------------------------------------
package tvmv_pkg;

    localparam int REQ_TAG_W = 31;
    localparam logic [REQ_TAG_W-1:0] REQ_TAG_RESET = 31'd35;

    // Register word index on the configuration port
    localparam logic REG_REQ_TAG = 1'b0;

    localparam logic [7:0] CH_PIPE  = 8'h7C;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    localparam logic [1:0] OUTCOME_DONE       = 2'd0;
    localparam logic [1:0] OUTCOME_BAD        = 2'd1;
    localparam logic [1:0] OUTCOME_INCOMPLETE = 2'd2;

    typedef enum logic [2:0] {
        PH_START   = 3'd0,
        PH_MINUS   = 3'd1,
        PH_DIGITS  = 3'd2,
        PH_REST    = 3'd3,
        PH_INVALID = 3'd4,
        PH_VALUE   = 3'd5
    } phase_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_present;
        logic       end_of_message;
    } item_t;

    typedef struct packed {
        logic       valid;
        logic [1:0] outcome;
    } result_t;

endpackage : tvmv_pkg
`default_nettype wire

// File: src/tvmv_in_stage.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tvmv_in_stage: input word register
// Captures one word per cycle unless the parser stalls; holds it until taken.
// ----------------------------------------------------------------------------
module tvmv_in_stage (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            s_valid,
    output logic                 s_ready,
    input  wire logic [7:0]      s_data_byte,
    input  wire logic            s_byte_present,
    input  wire logic            s_end_of_message,
    input  wire logic            adv,
    output logic                 item_valid,
    output tvmv_pkg::item_t      item
);

    logic            vld_reg, vld_next;
    tvmv_pkg::item_t item_reg, item_next;

    assign s_ready    = !vld_reg || adv;
    assign item_valid = vld_reg;
    assign item       = item_reg;

    always_comb begin
        vld_next  = vld_reg;
        item_next = item_reg;
        if (s_valid && s_ready) begin
            vld_next                 = 1'b1;
            item_next.data_byte      = s_data_byte;
            item_next.byte_present   = s_byte_present;
            item_next.end_of_message = s_end_of_message;
        end else if (adv) begin
            vld_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        item_reg <= item_next;
    end

endmodule : tvmv_in_stage
`default_nettype wire

// File: src/tvmv_parse_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tvmv_parse_core: field parser state and per-byte step
// Advances the field phase, tag accumulator and message flags by one word
// and forms the outcome when the word ends the message.
// ----------------------------------------------------------------------------
module tvmv_parse_core #(
    parameter int TAG_BITS = 32
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           item_valid,
    input  tvmv_pkg::item_t                     item,
    input  wire logic [tvmv_pkg::REQ_TAG_W-1:0] req_tag,
    input  wire logic                           out_free,
    output logic                                adv,
    output tvmv_pkg::result_t                   res
);

    localparam int CMP_W = (TAG_BITS > tvmv_pkg::REQ_TAG_W) ? TAG_BITS : tvmv_pkg::REQ_TAG_W;
    localparam int PROD_W = TAG_BITS + 4;
    localparam logic [TAG_BITS-1:0] HALF = {1'b1, {(TAG_BITS-1){1'b0}}};

    tvmv_pkg::phase_t    phase_reg, phase_next;
    logic [TAG_BITS-1:0] mag_reg, mag_next;
    logic                neg_reg, neg_next;
    logic                ovf_reg, ovf_next;
    logic                vne_reg, vne_next;
    logic                bad_reg, bad_next;
    logic                fdone_reg, fdone_next;
    logic                tail_reg, tail_next;

    logic [TAG_BITS-1:0] lim;
    logic [PROD_W-1:0]   prod;
    logic                digit_ovf;
    logic                is_digit;
    logic [3:0]          digit;
    logic                neg_nonzero;
    logic                is_req;
    logic                field_bad;
    logic                take_dig;
    logic [1:0]          outcome;

    assign adv = item_valid && (!item.end_of_message || out_free);

    always_comb begin
        // Digits are ASCII 0x30..0x39, so the low nibble is the value
        is_digit    = (item.data_byte >= tvmv_pkg::CH_ZERO) &&
                      (item.data_byte <= tvmv_pkg::CH_NINE);
        digit       = item.data_byte[3:0];
        lim         = neg_reg ? HALF : (HALF - 1'b1);
        prod        = ({4'b0000, mag_reg} << 3) + ({4'b0000, mag_reg} << 1) +
                      {{TAG_BITS{1'b0}}, digit};
        digit_ovf   = prod > {4'b0000, lim};
        neg_nonzero = neg_reg && (mag_reg != '0);
        is_req      = !neg_nonzero && (CMP_W'(mag_reg) == CMP_W'(req_tag));
        field_bad   = (phase_reg != tvmv_pkg::PH_VALUE) || (is_req && !vne_reg);

        phase_next = phase_reg;
        mag_next   = mag_reg;
        neg_next   = neg_reg;
        ovf_next   = ovf_reg;
        vne_next   = vne_reg;
        bad_next   = bad_reg;
        fdone_next = fdone_reg;
        tail_next  = tail_reg;
        take_dig   = 1'b0;

        if (item.byte_present) begin
            if (item.data_byte == tvmv_pkg::CH_PIPE) begin
                // Close the field and judge it
                if (field_bad) begin
                    bad_next = 1'b1;
                end
                fdone_next = 1'b1;
                tail_next  = 1'b0;
                phase_next = tvmv_pkg::PH_START;
                mag_next   = '0;
                neg_next   = 1'b0;
                ovf_next   = 1'b0;
                vne_next   = 1'b0;
            end else begin
                tail_next = 1'b1;
                unique case (phase_reg)
                    tvmv_pkg::PH_START: begin
                        if (item.data_byte == tvmv_pkg::CH_MINUS) begin
                            neg_next   = 1'b1;
                            phase_next = tvmv_pkg::PH_MINUS;
                        end else if (is_digit) begin
                            take_dig   = 1'b1;
                            phase_next = tvmv_pkg::PH_DIGITS;
                        end else begin
                            phase_next = tvmv_pkg::PH_INVALID;
                        end
                    end
                    tvmv_pkg::PH_MINUS: begin
                        if (is_digit) begin
                            take_dig   = 1'b1;
                            phase_next = tvmv_pkg::PH_DIGITS;
                        end else begin
                            phase_next = tvmv_pkg::PH_INVALID;
                        end
                    end
                    tvmv_pkg::PH_DIGITS, tvmv_pkg::PH_REST: begin
                        if (item.data_byte == tvmv_pkg::CH_EQ) begin
                            phase_next = ovf_reg ? tvmv_pkg::PH_INVALID : tvmv_pkg::PH_VALUE;
                        end else if (is_digit && (phase_reg == tvmv_pkg::PH_DIGITS)) begin
                            take_dig = 1'b1;
                        end else begin
                            phase_next = tvmv_pkg::PH_REST;
                        end
                    end
                    tvmv_pkg::PH_VALUE: begin
                        vne_next = 1'b1;
                    end
                    default: begin
                        phase_next = tvmv_pkg::PH_INVALID;
                    end
                endcase

                // Freeze the tag once it leaves the signed range
                if (take_dig && !ovf_reg) begin
                    if (digit_ovf) begin
                        ovf_next = 1'b1;
                    end else begin
                        mag_next = prod[TAG_BITS-1:0];
                    end
                end
            end
        end

        if (bad_next) begin
            outcome = tvmv_pkg::OUTCOME_BAD;
        end else if (!fdone_next || tail_next) begin
            outcome = tvmv_pkg::OUTCOME_INCOMPLETE;
        end else begin
            outcome = tvmv_pkg::OUTCOME_DONE;
        end

        if (item.end_of_message) begin
            phase_next = tvmv_pkg::PH_START;
            mag_next   = '0;
            neg_next   = 1'b0;
            ovf_next   = 1'b0;
            vne_next   = 1'b0;
            bad_next   = 1'b0;
            fdone_next = 1'b0;
            tail_next  = 1'b0;
        end
    end

    assign res.valid   = adv && item.end_of_message;
    assign res.outcome = outcome;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= tvmv_pkg::PH_START;
            mag_reg   <= '0;
            neg_reg   <= 1'b0;
            ovf_reg   <= 1'b0;
            vne_reg   <= 1'b0;
            bad_reg   <= 1'b0;
            fdone_reg <= 1'b0;
            tail_reg  <= 1'b0;
        end else if (adv) begin
            phase_reg <= phase_next;
            mag_reg   <= mag_next;
            neg_reg   <= neg_next;
            ovf_reg   <= ovf_next;
            vne_reg   <= vne_next;
            bad_reg   <= bad_next;
            fdone_reg <= fdone_next;
            tail_reg  <= tail_next;
        end
    end

    // Message end leaves every flag and the phase cleared
    a_eom_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (adv && item.end_of_message) |=>
            (phase_reg == tvmv_pkg::PH_START) && !bad_reg && !fdone_reg && !tail_reg &&
            (mag_reg == '0))
        else $error("state not cleared after message end");

    // Field delimiter closes the field and restarts the tag
    a_pipe_closes: assert property (@(posedge aclk) disable iff (!aresetn)
        (adv && item.byte_present && !item.end_of_message &&
         (item.data_byte == tvmv_pkg::CH_PIPE)) |=>
            fdone_reg && !tail_reg && (phase_reg == tvmv_pkg::PH_START) && !neg_reg)
        else $error("field not closed by delimiter");

    // Accumulated tag never goes past the negative limit
    a_mag_range: assert property (@(posedge aclk) disable iff (!aresetn)
        mag_reg <= HALF)
        else $error("tag magnitude out of range");

    // Overflow only arises while in or after the tag digits
    a_ovf_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        ovf_reg |-> ((phase_reg == tvmv_pkg::PH_DIGITS) || (phase_reg == tvmv_pkg::PH_REST) ||
                     (phase_reg == tvmv_pkg::PH_INVALID)))
        else $error("tag overflow outside tag phases");

endmodule : tvmv_parse_core
`default_nettype wire

// File: src/tvmv_out_stage.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tvmv_out_stage: result word register
// Holds one outcome word until the consumer takes it.
// ----------------------------------------------------------------------------
module tvmv_out_stage (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  tvmv_pkg::result_t res,
    output logic             out_free,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [1:0]       m_outcome
);

    logic       vld_reg, vld_next;
    logic [1:0] outcome_reg, outcome_next;

    assign out_free  = !vld_reg || m_ready;
    assign m_valid   = vld_reg;
    assign m_outcome = outcome_reg;

    always_comb begin
        vld_next     = vld_reg;
        outcome_next = outcome_reg;
        if (res.valid) begin
            vld_next     = 1'b1;
            outcome_next = res.outcome;
        end else if (m_ready) begin
            vld_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        outcome_reg <= outcome_next;
    end

endmodule : tvmv_out_stage
`default_nettype wire

// File: src/tag_value_message_validator_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tag_value_message_validator_unit: tag=value message validator
// Checks a byte stream of '|'-terminated tag=value fields and reports one
// outcome word (done, bad, incomplete) per message.
// ----------------------------------------------------------------------------
// Outcome path: input register, then result register, which drives m_valid.
// Throughput: one word per cycle, but a message-ending word waits while the
//   result register is full and m_ready is low; the per-byte step is a single
//   pass through the tag multiply-by-ten add and compare.
// Reset (aresetn low, synchronous): empties both registers, returns the parser
//   to tag start with all flags clear and sets req_tag_reg to 35.
// ----------------------------------------------------------------------------
module tag_value_message_validator_unit #(
    parameter int TAG_BITS = 32
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,

    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,

    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [7:0]  s_data_byte,
    input  wire logic        s_byte_present,
    input  wire logic        s_end_of_message,

    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [1:0]       m_outcome
);

    logic [tvmv_pkg::REQ_TAG_W-1:0] req_tag_reg, req_tag_next;

    logic              item_valid;
    tvmv_pkg::item_t   item;
    logic              adv;
    logic              out_free;
    tvmv_pkg::result_t res;

    assign pready = 1'b1;

    always_comb begin
        req_tag_next = req_tag_reg;
        if (psel && penable && pwrite && (paddr[2] == tvmv_pkg::REG_REQ_TAG)) begin
            req_tag_next = pwdata[tvmv_pkg::REQ_TAG_W-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[2] == tvmv_pkg::REG_REQ_TAG) begin
            prdata = {1'b0, req_tag_reg};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            req_tag_reg <= tvmv_pkg::REQ_TAG_RESET;
        end else begin
            req_tag_reg <= req_tag_next;
        end
    end

    tvmv_in_stage u_in_stage (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_data_byte      (s_data_byte),
        .s_byte_present   (s_byte_present),
        .s_end_of_message (s_end_of_message),
        .adv              (adv),
        .item_valid       (item_valid),
        .item             (item)
    );

    tvmv_parse_core #(
        .TAG_BITS (TAG_BITS)
    ) u_parse_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .item_valid (item_valid),
        .item       (item),
        .req_tag    (req_tag_reg),
        .out_free   (out_free),
        .adv        (adv),
        .res        (res)
    );

    tvmv_out_stage u_out_stage (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .res       (res),
        .out_free  (out_free),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_outcome (m_outcome)
    );

endmodule : tag_value_message_validator_unit
`default_nettype wire

// File: tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: testbench for tag_value_message_validator_unit
// Sends tag=value messages one byte word at a time, predicts the outcome of
// each message with its own parser, and checks each outcome word in order.
// It covers directed fields, tag limits, the required tag register and
// random messages, with random idling on both sides and a long output stall.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int TAG_BITS = 32;
    localparam int REQ_W = tvmv_pkg::REQ_TAG_W;
    localparam logic [2:0] REQ_TAG_ADDR = {tvmv_pkg::REG_REQ_TAG, 2'b00};
    localparam logic [REQ_W-1:0] REQ_TAG_MAX = '1;
    localparam int HOLD_CYCLES = 300;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        s_valid;
    logic        s_ready;
    logic [7:0]  s_data_byte;
    logic        s_byte_present;
    logic        s_end_of_message;
    logic        m_valid;
    logic        m_ready;
    logic [1:0]  m_outcome;

    // Parser copy used to predict outcomes
    tvmv_pkg::phase_t      ph;
    logic [63:0]           tag_mag;
    logic                  tag_neg;
    logic                  tag_ovf;
    logic                  val_nonempty;
    logic                  bad_seen;
    logic                  field_done;
    logic                  tail_open;
    logic [REQ_W-1:0]      req_tag;

    logic [1:0]  pending_outcomes[$];
    logic [7:0]  msg_bytes[$];
    string       limit_tags[8] = '{"2147483647", "2147483648", "-2147483648",
                                   "-2147483649", "99999999999", "-0", "0000035", "0"};

    int  errors = 0;
    int  words_sent = 0;
    int  messages_sent = 0;
    int  results_seen = 0;
    int  cfg_writes = 0;
    int  hold_requests = 0;
    bit  tx_idle_on = 1'b1;
    bit  rx_idle_on = 1'b1;

    tag_value_message_validator_unit #(.TAG_BITS(TAG_BITS)) dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_data_byte      (s_data_byte),
        .s_byte_present   (s_byte_present),
        .s_end_of_message (s_end_of_message),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_outcome        (m_outcome)
    );

    always #1 aclk = ~aclk;

    // ------------------------------------------------------------------
    // Outcome predictor
    // ------------------------------------------------------------------
    function automatic void restart_field();
        ph = tvmv_pkg::PH_START;
        tag_mag = '0;
        tag_neg = 1'b0;
        tag_ovf = 1'b0;
        val_nonempty = 1'b0;
    endfunction

    function automatic void restart_message();
        restart_field();
        bad_seen = 1'b0;
        field_done = 1'b0;
        tail_open = 1'b0;
    endfunction

    function automatic void push_digit(input logic [7:0] b);
        logic [63:0] lim;
        logic [63:0] d;
        d = {56'd0, b - tvmv_pkg::CH_ZERO};
        lim = (64'd1 << (TAG_BITS - 1)) - (tag_neg ? 64'd0 : 64'd1);
        // magnitude freezes once it leaves the signed range
        if (!tag_ovf) begin
            if (tag_mag > (lim - d) / 10)
                tag_ovf = 1'b1;
            else
                tag_mag = tag_mag * 10 + d;
        end
    endfunction

    function automatic void close_field();
        logic bad;
        bad = 1'b1;
        if (ph == tvmv_pkg::PH_VALUE) begin
            bad = !(tag_neg && tag_mag != 0) && tag_mag == {33'd0, req_tag}
                  && !val_nonempty;
        end
        if (bad)
            bad_seen = 1'b1;
        field_done = 1'b1;
        tail_open = 1'b0;
        restart_field();
    endfunction

    function automatic void parse_byte(input logic [7:0] b);
        logic is_digit;
        is_digit = (b >= tvmv_pkg::CH_ZERO) && (b <= tvmv_pkg::CH_NINE);
        if (b == tvmv_pkg::CH_PIPE) begin
            close_field();
        end else begin
            tail_open = 1'b1;
            case (ph)
                tvmv_pkg::PH_START: begin
                    if (b == tvmv_pkg::CH_MINUS) begin
                        tag_neg = 1'b1;
                        ph = tvmv_pkg::PH_MINUS;
                    end else if (is_digit) begin
                        push_digit(b);
                        ph = tvmv_pkg::PH_DIGITS;
                    end else begin
                        ph = tvmv_pkg::PH_INVALID;
                    end
                end
                tvmv_pkg::PH_MINUS: begin
                    if (is_digit) begin
                        push_digit(b);
                        ph = tvmv_pkg::PH_DIGITS;
                    end else begin
                        ph = tvmv_pkg::PH_INVALID;
                    end
                end
                tvmv_pkg::PH_DIGITS, tvmv_pkg::PH_REST: begin
                    if (b == tvmv_pkg::CH_EQ)
                        ph = tag_ovf ? tvmv_pkg::PH_INVALID : tvmv_pkg::PH_VALUE;
                    else if (is_digit && ph == tvmv_pkg::PH_DIGITS)
                        push_digit(b);
                    else
                        ph = tvmv_pkg::PH_REST;
                end
                tvmv_pkg::PH_VALUE: val_nonempty = 1'b1;
                default: ph = tvmv_pkg::PH_INVALID;
            endcase
        end
    endfunction

    function automatic logic [1:0] message_outcome();
        logic [1:0] res;
        if (bad_seen)
            res = tvmv_pkg::OUTCOME_BAD;
        else if (!field_done || tail_open)
            res = tvmv_pkg::OUTCOME_INCOMPLETE;
        else
            res = tvmv_pkg::OUTCOME_DONE;
        restart_message();
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Message building
    // ------------------------------------------------------------------
    function automatic void add_byte(input logic [7:0] b);
        msg_bytes.push_back(b);
    endfunction

    function automatic void add_text(input string s);
        for (int i = 0; i < s.len(); i++)
            msg_bytes.push_back(s[i]);
    endfunction

    // any byte but the field separator, and not '=' when no_eq is set
    function automatic logic [7:0] random_text_byte(input bit no_eq);
        logic [7:0] b;
        b = 8'($urandom_range(255));
        while (b == tvmv_pkg::CH_PIPE || (no_eq && b == tvmv_pkg::CH_EQ))
            b = 8'($urandom_range(255));
        return b;
    endfunction

    function automatic void add_random_field(input bit leave_open);
        longint unsigned n;
        logic [7:0]      b;
        case ($urandom_range(9))
            0, 1: add_text($sformatf("%0d", req_tag));
            2: add_text($sformatf("-%0d", req_tag));
            3: add_text($sformatf("%0d", $urandom_range(999)));
            4: begin
                n = $urandom();
                add_text($sformatf("%0d", n));
            end
            5: add_text(limit_tags[$urandom_range(7)]);
            6: ;  // empty tag
            7: begin
                b = random_text_byte(1'b0);
                while ((b >= tvmv_pkg::CH_ZERO && b <= tvmv_pkg::CH_NINE) ||
                       b == tvmv_pkg::CH_MINUS)
                    b = random_text_byte(1'b0);
                add_byte(b);
            end
            8: begin
                add_byte(tvmv_pkg::CH_MINUS);
                if ($urandom_range(1) != 0)
                    add_byte(random_text_byte(1'b0));
            end
            default: add_text($sformatf("-%0d", $urandom_range(99999)));
        endcase
        if ($urandom_range(4) == 0) begin
            repeat ($urandom_range(1, 3)) add_byte(random_text_byte(1'b1));
        end
        if ($urandom_range(9) != 0) begin
            add_byte(tvmv_pkg::CH_EQ);
            if ($urandom_range(2) != 0) begin
                repeat ($urandom_range(1, 4)) add_byte(random_text_byte(1'b0));
            end
        end
        if (!leave_open)
            add_byte(tvmv_pkg::CH_PIPE);
    endfunction

    function automatic void build_random_message();
        int fields;
        if ($urandom_range(99) < 15) begin
            // raw noise, separator-heavy
            repeat ($urandom_range(12)) begin
                if ($urandom_range(3) == 0)
                    add_byte(tvmv_pkg::CH_PIPE);
                else
                    add_byte(8'($urandom_range(255)));
            end
        end else begin
            fields = $urandom_range(1, 4);
            for (int f = 0; f < fields; f++)
                add_random_field(f == fields - 1 && $urandom_range(9) == 0);
        end
    endfunction

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------
    task automatic send_word(input logic [7:0] b, input logic present, input logic last);
        while (tx_idle_on && $urandom_range(99) < 17) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data_byte <= b;
        s_byte_present <= present;
        s_end_of_message <= last;
        if (present)
            parse_byte(b);
        if (last)
            pending_outcomes.push_back(message_outcome());
        words_sent++;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic send_message(input bit bare_end);
        int n;
        bit bare;
        n = msg_bytes.size();
        bare = bare_end || n == 0;
        for (int i = 0; i < n; i++) begin
            // ignored filler word with random data
            if ($urandom_range(19) == 0)
                send_word(8'($urandom_range(255)), 1'b0, 1'b0);
            send_word(msg_bytes[i], 1'b1, !bare && i == n - 1);
        end
        if (bare)
            send_word(8'($urandom_range(255)), 1'b0, 1'b1);
        msg_bytes.delete();
        messages_sent++;
    endtask

    task automatic send_text(input string s, input bit bare_end);
        add_text(s);
        send_message(bare_end);
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        while (pending_outcomes.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_required_tag(input logic [REQ_W-1:0] v);
        @(posedge aclk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= REQ_TAG_ADDR;
        pwdata <= {{(32 - REQ_W){1'b0}}, v};
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        req_tag = v;
        cfg_writes++;
    endtask

    task automatic check_required_tag();
        @(posedge aclk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= REQ_TAG_ADDR;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        if (prdata[REQ_W-1:0] !== req_tag) begin
            errors++;
            $display("%0t ERROR: required tag readback expected %0d actual %0d",
                     $time, req_tag, prdata[REQ_W-1:0]);
        end
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Result side: random stalls plus long hold-offs on request
    // ------------------------------------------------------------------
    initial begin : result_sink
        int hold_left;
        int holds_taken;
        hold_left = 0;
        holds_taken = 0;
        m_ready = 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_requests != holds_taken) begin
                holds_taken = hold_requests;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if (rx_idle_on && $urandom_range(99) < 17) begin
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    initial begin : outcome_checker
        logic [1:0] want;
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready) begin
                results_seen++;
                if (pending_outcomes.size() == 0) begin
                    errors++;
                    $display("%0t ERROR: outcome with none expected, expected none actual %0d",
                             $time, m_outcome);
                end else begin
                    want = pending_outcomes.pop_front();
                    if (m_outcome !== want) begin
                        errors++;
                        $display("%0t ERROR: outcome expected %0d actual %0d",
                                 $time, want, m_outcome);
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_register_access();
        check_required_tag();
        write_required_tag('0);
        check_required_tag();
        write_required_tag(REQ_TAG_MAX);
        check_required_tag();
        write_required_tag(tvmv_pkg::REQ_TAG_RESET);
        check_required_tag();
    endtask

    task automatic test_directed_fields();
        send_text("35=|", 1'b0);            // required tag, empty value
        send_text("8=FIX|35=A|", 1'b0);
        send_text("", 1'b1);                 // bare end, nothing seen
        send_text("1=x|2", 1'b0);            // unterminated tail
        send_text("1=x|-", 1'b1);            // bad tail never judged
        send_text("=x|", 1'b0);
        send_text("abc|", 1'b0);
        send_text("-0=|", 1'b0);
        send_text("2147483647=1|-2147483648=1|", 1'b0);
        send_text("2147483648=1|", 1'b0);
        send_text("-2147483649=1|", 1'b1);
        send_text("12xy=a=b|", 1'b0);        // tag rest ignored, '=' in value
        send_text("--1=2|", 1'b0);
        add_text("9=");
        add_byte(8'hFF);
        add_byte(8'h00);
        add_byte(tvmv_pkg::CH_PIPE);
        send_message(1'b0);
        drain_results();
    endtask

    task automatic test_required_tag_extremes();
        logic [REQ_W-1:0] picks[3];
        picks = '{'0, REQ_TAG_MAX, REQ_W'($urandom())};
        foreach (picks[k]) begin
            write_required_tag(picks[k]);
            send_text("-0=|", 1'b0);
            send_text("0=|", 1'b0);
            send_text("2147483647=|", 1'b0);
            send_text($sformatf("%0d=|", req_tag), 1'b0);
            send_text($sformatf("%0d=v|", req_tag), 1'b1);
            send_text($sformatf("-%0d=|", req_tag), 1'b0);
            drain_results();
        end
    endtask

    task automatic test_backpressure_fill();
        hold_requests <= hold_requests + 1;
        repeat (12) begin
            send_text("7=x|", 1'b0);
            send_text("", 1'b1);
        end
        drain_results();
    endtask

    task automatic test_back_to_back();
        int start;
        tx_idle_on = 1'b0;
        rx_idle_on <= 1'b0;
        start = words_sent;
        while (words_sent - start < 80) begin
            build_random_message();
            send_message($urandom_range(4) == 0);
        end
        drain_results();
        tx_idle_on = 1'b1;
        rx_idle_on <= 1'b1;
    endtask

    task automatic test_random_messages();
        logic [REQ_W-1:0] picks[5];
        int start;
        picks = '{REQ_W'($urandom()), '0, REQ_TAG_MAX,
                  REQ_W'($urandom_range(200)), tvmv_pkg::REQ_TAG_RESET};
        foreach (picks[k]) begin
            write_required_tag(picks[k]);
            start = words_sent;
            while (words_sent - start < 40) begin
                build_random_message();
                send_message($urandom_range(4) == 0);
            end
            drain_results();
        end
    endtask

    initial begin
        aresetn = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        s_valid = 1'b0;
        s_data_byte = '0;
        s_byte_present = 1'b0;
        s_end_of_message = 1'b0;
        req_tag = tvmv_pkg::REQ_TAG_RESET;
        restart_message();
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_register_access();
        test_directed_fields();
        test_required_tag_extremes();
        test_backpressure_fill();
        test_back_to_back();
        test_random_messages();

        drain_results();
        repeat (8) @(posedge aclk);
        $display("covered %0d messages in %0d words: directed fields, tag limits,",
                 messages_sent, words_sent);
        $display("required tag 0/35/max, output stall fill; %0d outcomes, %0d writes, %0d errors",
                 results_seen, cfg_writes, errors);
        if (errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    initial begin
        #400000;
        $display("timeout with %0d outcomes still pending", pending_outcomes.size());
        $display("simulation failed");
        $finish;
    end

endmodule : tb_top
